/* hdl/mtc_pkg.sv */
// Shared types, constants and helpers for the MAC traffic counter tables.
package mtc_pkg;

    // Default sizes and fixed field widths
    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_COUNTER_BITS  = 48;
    localparam int LANE_LIMIT        = 16;
    localparam int MAC_W             = 48;
    localparam int LEN_W             = 16;
    localparam int IDX_W             = 6;
    localparam int OUT_W             = 48;

    // Input transaction codes
    localparam logic ACTION_ACCOUNT = 1'b0;
    localparam logic ACTION_READ    = 1'b1;
    localparam logic TABLE_DEST     = 1'b1;

    // Per-table outcome of one packet
    typedef enum logic [1:0] {
        STATUS_HIT    = 2'd0,
        STATUS_INSERT = 2'd1,
        STATUS_DROP   = 2'd2
    } status_t;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MERGE,
        ST_UPDATE,
        ST_READ,
        ST_FINISH
    } state_t;

    // Control group from the sequencer to both tables
    typedef struct packed {
        logic clear;   // drop the sticky hits of the previous search
        logic rd_en;   // read one row in every lane
        logic merge;   // combine the lane results
        logic commit;  // write the counter back or insert the address
    } tbl_ctrl_t;

    // Number of parallel lanes: largest power of two below the depth, capped
    function automatic int lane_count(input int entries);
        int lanes;
        lanes = 1;
        while ((lanes * 2 < entries) && (lanes < LANE_LIMIT)) begin
            lanes = lanes * 2;
        end
        return lanes;
    endfunction

    // Saturating add at a given counter width
    function automatic logic [63:0] cnt_sat_add(input logic [63:0] acc,
                                                input logic [63:0] inc,
                                                input int          bits);
        logic [64:0] sum;
        logic [63:0] max_val;
        sum     = {1'b0, acc} + {1'b0, inc};
        max_val = (~64'd0) >> (64 - bits);
        return (sum > {1'b0, max_val}) ? max_val : sum[63:0];
    endfunction

endpackage

/* hdl/mtc_lane.sv */
// One search lane: a bank of table rows with its own address compare.
module mtc_lane #(
    parameter int  TABLE_ENTRIES = mtc_pkg::DEF_TABLE_ENTRIES,
    parameter int  COUNTER_BITS  = mtc_pkg::DEF_COUNTER_BITS,
    parameter int  LANE_ID       = 0,
    localparam int LANES  = mtc_pkg::lane_count(TABLE_ENTRIES),
    localparam int ROWS   = (TABLE_ENTRIES + LANES - 1) / LANES,
    localparam int ROW_W  = $clog2(ROWS),
    localparam int SLOT_W = $clog2(ROWS * LANES),
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1),
    localparam int WORD_W = mtc_pkg::MAC_W + COUNTER_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mtc_pkg::tbl_ctrl_t       ctrl,
    input  logic [ROW_W-1:0]         rd_row,
    input  logic [mtc_pkg::MAC_W-1:0] key,
    input  logic [FILL_W-1:0]        fill,
    input  logic                     wr_en,
    input  logic [ROW_W-1:0]         wr_row,
    input  logic [WORD_W-1:0]        wr_word,
    output logic                     hit,
    output logic [ROW_W-1:0]         hit_row,
    output logic [COUNTER_BITS-1:0]  hit_cnt,
    output logic [WORD_W-1:0]        rd_word
);
    import mtc_pkg::*;

    logic [WORD_W-1:0]       mem [ROWS];
    logic [WORD_W-1:0]       rd_word_reg;
    logic [ROW_W-1:0]        cmp_row_reg;
    logic                    cmp_vld_reg;
    logic                    hit_reg;
    logic [ROW_W-1:0]        hit_row_reg;
    logic [COUNTER_BITS-1:0] hit_cnt_reg;
    logic [SLOT_W:0]         cmp_slot;
    logic                    occupied;
    logic                    match;

    // Bank storage: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_word;
        end
        if (ctrl.rd_en) begin
            rd_word_reg <= mem[rd_row];
            cmp_row_reg <= rd_row;
        end
    end

    // Compare the row read last cycle; only filled slots take part
    always_comb begin
        cmp_slot = (SLOT_W+1)'(cmp_row_reg) * (SLOT_W+1)'(LANES) + (SLOT_W+1)'(LANE_ID);
        occupied = cmp_slot < (SLOT_W+1)'(fill);
        match    = cmp_vld_reg && occupied && (rd_word_reg[WORD_W-1 -: MAC_W] == key);
    end

    // Hold the hit until the next search starts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end else begin
            cmp_vld_reg <= ctrl.rd_en;
            if (ctrl.clear) begin
                hit_reg <= 1'b0;
            end else if (match) begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (match) begin
            hit_row_reg <= cmp_row_reg;
            hit_cnt_reg <= rd_word_reg[COUNTER_BITS-1:0];
        end
    end

    assign hit     = hit_reg;
    assign hit_row = hit_row_reg;
    assign hit_cnt = hit_cnt_reg;
    assign rd_word = rd_word_reg;

endmodule

/* hdl/mtc_table.sv */
// One MAC table: parallel search lanes, merge stage, fill count and update.
module mtc_table #(
    parameter int  TABLE_ENTRIES = mtc_pkg::DEF_TABLE_ENTRIES,
    parameter int  COUNTER_BITS  = mtc_pkg::DEF_COUNTER_BITS,
    localparam int LANES  = mtc_pkg::lane_count(TABLE_ENTRIES),
    localparam int ROWS   = (TABLE_ENTRIES + LANES - 1) / LANES,
    localparam int ROW_W  = $clog2(ROWS),
    localparam int SLOT_W = $clog2(ROWS * LANES)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mtc_pkg::tbl_ctrl_t        ctrl,
    input  logic [ROW_W-1:0]          rd_row,
    input  logic [SLOT_W-1:0]         rd_slot,
    input  logic [mtc_pkg::MAC_W-1:0] key,
    input  logic [COUNTER_BITS-1:0]   inc,
    output logic                      rd_occupied,
    output logic [mtc_pkg::MAC_W-1:0] rd_mac,
    output logic [COUNTER_BITS-1:0]   rd_cnt,
    output mtc_pkg::status_t          status
);
    import mtc_pkg::*;

    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
    localparam int WORD_W = MAC_W + COUNTER_BITS;

    logic [FILL_W-1:0]       fill_reg;
    status_t                 status_reg;
    logic [LANE_W-1:0]       tgt_lane_reg;
    logic [ROW_W-1:0]        tgt_row_reg;
    logic [COUNTER_BITS-1:0] base_cnt_reg;

    logic [LANES-1:0]        lane_hit;
    logic [ROW_W-1:0]        lane_row  [LANES];
    logic [COUNTER_BITS-1:0] lane_cnt  [LANES];
    logic [WORD_W-1:0]       lane_word [LANES];
    logic [LANES-1:0]        lane_wr_en;

    logic                    any_hit;
    logic [LANE_W-1:0]       m_lane;
    logic [ROW_W-1:0]        m_row;
    logic [COUNTER_BITS-1:0] m_cnt;
    logic [LANE_W-1:0]       free_lane;
    logic [ROW_W-1:0]        free_row;
    logic                    full;
    logic [LANE_W-1:0]       rd_lane;
    logic [WORD_W-1:0]       rd_word_sel;
    logic [COUNTER_BITS-1:0] new_cnt;
    logic [WORD_W-1:0]       wr_word;

    // Lanes: slot s lives in lane s % LANES, row s / LANES
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        mtc_lane #(
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .COUNTER_BITS  (COUNTER_BITS),
            .LANE_ID       (l)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .rd_row  (rd_row),
            .key     (key),
            .fill    (fill_reg),
            .wr_en   (lane_wr_en[l]),
            .wr_row  (tgt_row_reg),
            .wr_word (wr_word),
            .hit     (lane_hit[l]),
            .hit_row (lane_row[l]),
            .hit_cnt (lane_cnt[l]),
            .rd_word (lane_word[l])
        );
    end

    // Merge: addresses are unique, so at most one lane hits
    always_comb begin
        any_hit = |lane_hit;
        m_lane  = '0;
        m_row   = '0;
        m_cnt   = '0;
        for (int l = 0; l < LANES; l++) begin
            if (lane_hit[l]) begin
                m_lane = m_lane | LANE_W'(l);
                m_row  = m_row | lane_row[l];
                m_cnt  = m_cnt | lane_cnt[l];
            end
        end
    end

    // Slots fill in order and never empty, so the lowest free slot is the fill count
    always_comb begin
        free_lane = LANE_W'(fill_reg % LANES);
        free_row  = ROW_W'(fill_reg / LANES);
        full      = (fill_reg == FILL_W'(TABLE_ENTRIES));
    end

    // Read-back select
    always_comb begin
        rd_lane     = LANE_W'(rd_slot % LANES);
        rd_word_sel = '0;
        for (int l = 0; l < LANES; l++) begin
            if (rd_lane == LANE_W'(l)) begin
                rd_word_sel = rd_word_sel | lane_word[l];
            end
        end
    end

    // Update: saturating counter written back to the chosen slot
    always_comb begin
        new_cnt = COUNTER_BITS'(cnt_sat_add(64'(base_cnt_reg), 64'(inc), COUNTER_BITS));
        wr_word = {key, new_cnt};
        for (int l = 0; l < LANES; l++) begin
            lane_wr_en[l] = ctrl.commit && (status_reg != STATUS_DROP)
                            && (tgt_lane_reg == LANE_W'(l));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            status_reg <= STATUS_HIT;
        end else begin
            if (ctrl.merge) begin
                if (any_hit) begin
                    status_reg <= STATUS_HIT;
                end else if (full) begin
                    status_reg <= STATUS_DROP;
                end else begin
                    status_reg <= STATUS_INSERT;
                end
            end
            if (ctrl.commit && (status_reg == STATUS_INSERT)) begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.merge) begin
            tgt_lane_reg <= any_hit ? m_lane : free_lane;
            tgt_row_reg  <= any_hit ? m_row : free_row;
            base_cnt_reg <= any_hit ? m_cnt : '0;
        end
    end

    assign rd_occupied = (SLOT_W+1)'(rd_slot) < (SLOT_W+1)'(fill_reg);
    assign rd_mac      = rd_word_sel[WORD_W-1 -: MAC_W];
    assign rd_cnt      = rd_word_sel[COUNTER_BITS-1:0];
    assign status      = status_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(TABLE_ENTRIES))
        else $error("fill count beyond table depth");

    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.merge |-> $onehot0(lane_hit))
        else $error("address found in more than one lane");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != $past(fill_reg)) |->
            ($past(ctrl.commit) && ($past(status_reg) == STATUS_INSERT)
             && (fill_reg == $past(fill_reg) + 1'b1)))
        else $error("fill count moved without an insertion");
`endif

endmodule

/* hdl/mac_traffic_counter_table.sv */
// Top level of the per-MAC traffic counter tables.
//
// Each account transaction looks up its source MAC in the source table and its
// destination MAC in the destination table, adds one (or the frame length when
// byte_mode is set) to the matching counter, or inserts the address into the
// next free slot, and bumps the global packet and byte totals; a full table
// reports a drop for that address only. A read transaction returns one slot
// and the totals without changing anything. Each table of TABLE_ENTRIES slots
// is split over LANES = min(16, largest power of two below TABLE_ENTRIES)
// banks that are searched side by side one row per cycle across all the
// ROWS = ceil(TABLE_ENTRIES / LANES) rows of each bank. An account transaction
// steps through scan, drain, merge, update and finish; a read transaction
// steps through read and finish. The result is held in an output register
// until taken; a new transaction is accepted as soon as the block is idle.
// Counters and totals saturate at COUNTER_BITS bits and are shown on 48-bit
// ports. Slots fill in order, so a fill count stands in for per-slot valid
// bits and no clearing pass follows reset.
module mac_traffic_counter_table #(
    parameter int TABLE_ENTRIES = mtc_pkg::DEF_TABLE_ENTRIES,
    parameter int COUNTER_BITS  = mtc_pkg::DEF_COUNTER_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_write_en,
    input  logic                      cfg_write_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic [mtc_pkg::MAC_W-1:0] s_dest_mac,
    input  logic [mtc_pkg::MAC_W-1:0] s_source_mac,
    input  logic [mtc_pkg::LEN_W-1:0] s_frame_length,
    input  logic                      s_table_select,
    input  logic [mtc_pkg::IDX_W-1:0] s_entry_index,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_entry_valid,
    output logic [mtc_pkg::MAC_W-1:0] m_entry_mac,
    output logic [mtc_pkg::OUT_W-1:0] m_entry_count,
    output logic [mtc_pkg::OUT_W-1:0] m_total_packets,
    output logic [mtc_pkg::OUT_W-1:0] m_total_bytes,
    output logic [1:0]                m_source_status,
    output logic [1:0]                m_dest_status
);
    import mtc_pkg::*;

    localparam int LANES  = lane_count(TABLE_ENTRIES);
    localparam int ROWS   = (TABLE_ENTRIES + LANES - 1) / LANES;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int SLOT_W = $clog2(ROWS * LANES);

    state_t                  state_reg, state_next;
    logic [ROW_W-1:0]        row_cnt_reg, row_cnt_next;
    logic                    byte_mode_reg;

    logic                    action_reg;
    logic [MAC_W-1:0]        dmac_reg;
    logic [MAC_W-1:0]        smac_reg;
    logic [LEN_W-1:0]        len_reg;
    logic                    sel_reg;
    logic [IDX_W-1:0]        idx_reg;

    logic [COUNTER_BITS-1:0] pkt_total_reg;
    logic [COUNTER_BITS-1:0] byte_total_reg;

    logic                    m_valid_reg;
    logic                    e_valid_reg;
    logic [MAC_W-1:0]        e_mac_reg;
    logic [OUT_W-1:0]        e_cnt_reg;
    logic [OUT_W-1:0]        tot_pkt_reg;
    logic [OUT_W-1:0]        tot_byte_reg;
    status_t                 src_status_reg;
    status_t                 dst_status_reg;

    tbl_ctrl_t               ctrl;
    logic                    accept;
    logic                    load_out;
    logic                    idx_in_range;
    logic [SLOT_W-1:0]       rd_slot;
    logic [ROW_W-1:0]        rd_row;
    logic [COUNTER_BITS-1:0] inc;

    logic                    src_occupied, dst_occupied;
    logic [MAC_W-1:0]        src_mac, dst_mac;
    logic [COUNTER_BITS-1:0] src_cnt, dst_cnt;
    status_t                 src_status, dst_status;

    logic                    sel_occupied;
    logic [MAC_W-1:0]        sel_mac;
    logic [COUNTER_BITS-1:0] sel_cnt;

    // Next state
    always_comb begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                row_cnt_next = '0;
                if (s_valid) begin
                    state_next = (s_action == ACTION_READ) ? ST_READ : ST_SCAN;
                end
            end
            ST_SCAN: begin
                row_cnt_next = row_cnt_reg + 1'b1;
                if (row_cnt_reg == ROW_W'(ROWS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_MERGE;
            ST_MERGE:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_FINISH;
            ST_READ:   state_next = ST_FINISH;
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        accept       = s_valid && s_ready;
        load_out     = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
        ctrl.clear   = accept && (s_action == ACTION_ACCOUNT);
        ctrl.rd_en   = (state_reg == ST_SCAN) || ((state_reg == ST_READ) && idx_in_range);
        ctrl.merge   = (state_reg == ST_MERGE);
        ctrl.commit  = (state_reg == ST_UPDATE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            row_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_mode_reg <= 1'b0;
        end else if (cfg_write_en) begin
            byte_mode_reg <= cfg_write_data;
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge aclk) begin
        if (accept) begin
            action_reg <= s_action;
            dmac_reg   <= s_dest_mac;
            smac_reg   <= s_source_mac;
            len_reg    <= s_frame_length;
            sel_reg    <= s_table_select;
            idx_reg    <= s_entry_index;
        end
    end

    // Table addressing and increment
    always_comb begin
        idx_in_range = (32'(idx_reg) < 32'(TABLE_ENTRIES));
        rd_slot      = SLOT_W'(idx_reg);
        rd_row       = (state_reg == ST_SCAN) ? row_cnt_reg : ROW_W'(rd_slot / LANES);
        inc          = byte_mode_reg ? COUNTER_BITS'(len_reg) : COUNTER_BITS'(1);
    end

    mtc_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNTER_BITS  (COUNTER_BITS)
    ) u_source (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .rd_row      (rd_row),
        .rd_slot     (rd_slot),
        .key         (smac_reg),
        .inc         (inc),
        .rd_occupied (src_occupied),
        .rd_mac      (src_mac),
        .rd_cnt      (src_cnt),
        .status      (src_status)
    );

    mtc_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNTER_BITS  (COUNTER_BITS)
    ) u_dest (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .rd_row      (rd_row),
        .rd_slot     (rd_slot),
        .key         (dmac_reg),
        .inc         (inc),
        .rd_occupied (dst_occupied),
        .rd_mac      (dst_mac),
        .rd_cnt      (dst_cnt),
        .status      (dst_status)
    );

    // Global totals advance once per account transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_total_reg  <= '0;
            byte_total_reg <= '0;
        end else if (ctrl.commit) begin
            pkt_total_reg  <= COUNTER_BITS'(cnt_sat_add(64'(pkt_total_reg), 64'd1,
                                                        COUNTER_BITS));
            byte_total_reg <= COUNTER_BITS'(cnt_sat_add(64'(byte_total_reg), 64'(len_reg),
                                                        COUNTER_BITS));
        end
    end

    // Pick the slot of the requested table
    always_comb begin
        sel_occupied = (sel_reg == TABLE_DEST) ? dst_occupied : src_occupied;
        sel_mac      = (sel_reg == TABLE_DEST) ? dst_mac : src_mac;
        sel_cnt      = (sel_reg == TABLE_DEST) ? dst_cnt : src_cnt;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            tot_pkt_reg  <= OUT_W'(pkt_total_reg);
            tot_byte_reg <= OUT_W'(byte_total_reg);
            if (action_reg == ACTION_READ) begin
                e_valid_reg    <= idx_in_range && sel_occupied;
                e_mac_reg      <= (idx_in_range && sel_occupied) ? sel_mac : '0;
                e_cnt_reg      <= (idx_in_range && sel_occupied) ? OUT_W'(sel_cnt) : '0;
                src_status_reg <= STATUS_HIT;
                dst_status_reg <= STATUS_HIT;
            end else begin
                e_valid_reg    <= 1'b0;
                e_mac_reg      <= '0;
                e_cnt_reg      <= '0;
                src_status_reg <= src_status;
                dst_status_reg <= dst_status;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_entry_valid   = e_valid_reg;
    assign m_entry_mac     = e_mac_reg;
    assign m_entry_count   = e_cnt_reg;
    assign m_total_packets = tot_pkt_reg;
    assign m_total_bytes   = tot_byte_reg;
    assign m_source_status = src_status_reg;
    assign m_dest_status   = dst_status_reg;

`ifndef NO_ASSERTIONS
    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");

    a_read_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && e_valid_reg) |->
            ((src_status_reg == STATUS_HIT) && (dst_status_reg == STATUS_HIT)))
        else $error("read result carries a packet status");

    a_totals_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        ((pkt_total_reg != $past(pkt_total_reg))
         || (byte_total_reg != $past(byte_total_reg))) |->
            $past(state_reg == ST_UPDATE))
        else $error("totals changed outside the update step");
`endif

endmodule
